### rtl/im2col_tile_address_generator_core_defines.svh
// Assertion macros shared by the im2col tile address generator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef IM2COL_TILE_ADDRESS_GENERATOR_CORE_DEFINES_SVH
`define IM2COL_TILE_ADDRESS_GENERATOR_CORE_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define ITAG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itag check failed");

// Check that holds in the cycle after its condition.
`define ITAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itag check failed");

`endif

### rtl/itag_pkg.sv
// Shared types, widths and layout tables of the im2col tile address generator.
// No dependencies; imported by every module of the block.
package itag_pkg;

  localparam int TILE_DIM   = 8;
  localparam int TILE_W     = (TILE_DIM > 1) ? $clog2(TILE_DIM) : 1;
  localparam int ADDR_W     = 48;
  localparam int BASE_W     = 32;
  localparam int DIM_W      = 13;
  localparam int N_W        = 9;
  localparam int MODE_W     = 3;
  localparam int IDX_W      = 16;
  localparam int RC_W       = IDX_W + TILE_W;
  localparam int DIV_W      = 24;
  localparam int DSR_W      = 25;
  localparam int K_W        = 3;
  localparam int PAD_W      = 2;
  localparam int TR_W       = N_W + DSR_W;
  localparam int TC_W       = 2 * K_W + DIM_W;
  localparam int STR_W      = 37;
  localparam int MUL_SPLIT  = 20;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TILE_W-1:0] TILE_LAST = TILE_W'(TILE_DIM - 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYOUT  = 3'd0,
    REG_BASE    = 3'd1,
    REG_BATCH   = 3'd2,
    REG_HEIGHT  = 3'd3,
    REG_WIDTH   = 3'd4,
    REG_CHANNEL = 3'd5
  } cfg_reg_t;

  // Layout codes.
  localparam logic [MODE_W-1:0] LAYOUT_K1S1P0 = 3'd0;
  localparam logic [MODE_W-1:0] LAYOUT_K3S1P1 = 3'd1;
  localparam logic [MODE_W-1:0] LAYOUT_K3S2P1 = 3'd2;
  localparam logic [MODE_W-1:0] LAYOUT_K5S1P2 = 3'd3;
  localparam logic [MODE_W-1:0] LAYOUT_K7S2P3 = 3'd4;

  // Element size codes.
  localparam logic [CODE_W-1:0] SIZE_1B = 2'd0;
  localparam logic [CODE_W-1:0] SIZE_2B = 2'd1;

  // Kernel size of a layout; zero marks an unknown layout.
  function automatic logic [K_W-1:0] lay_kernel(input logic [MODE_W-1:0] mode);
    case (mode)
      LAYOUT_K1S1P0: lay_kernel = 3'd1;
      LAYOUT_K3S1P1: lay_kernel = 3'd3;
      LAYOUT_K3S2P1: lay_kernel = 3'd3;
      LAYOUT_K5S1P2: lay_kernel = 3'd5;
      LAYOUT_K7S2P3: lay_kernel = 3'd7;
      default:       lay_kernel = 3'd0;
    endcase
  endfunction

  // High when the layout steps by two.
  function automatic logic lay_stride2(input logic [MODE_W-1:0] mode);
    lay_stride2 = (mode == LAYOUT_K3S2P1) || (mode == LAYOUT_K7S2P3);
  endfunction

  // Padding of a layout.
  function automatic logic [PAD_W-1:0] lay_pad(input logic [MODE_W-1:0] mode);
    case (mode)
      LAYOUT_K3S1P1: lay_pad = 2'd1;
      LAYOUT_K3S2P1: lay_pad = 2'd1;
      LAYOUT_K5S1P2: lay_pad = 2'd2;
      LAYOUT_K7S2P3: lay_pad = 2'd3;
      default:       lay_pad = 2'd0;
    endcase
  endfunction

  // Starting point of one tile, worked out by the setup unit.
  typedef struct packed {
    logic [RC_W-1:0]   r0;
    logic [RC_W-1:0]   q0;
    logic [DIM_W-1:0]  oh0;
    logic [DIM_W-1:0]  ow0;
    logic [ADDR_W-1:0] roff0;
    logic [DIM_W-1:0]  c0;
    logic [K_W-1:0]    kw0;
    logic [K_W-1:0]    kh0;
    logic [DIM_W-1:0]  oh_cnt;
    logic [DIM_W-1:0]  ow_cnt;
    logic [K_W-1:0]    kern;
    logic              stride2;
    logic [PAD_W-1:0]  pad;
    logic [TR_W-1:0]   total_rows;
    logic [TC_W-1:0]   total_cols;
    logic [DIM_W-1:0]  img_h;
    logic [DIM_W-1:0]  img_w;
    logic [DIM_W-1:0]  chan;
    logic [STR_W-1:0]  img_stride;
    logic [CODE_W-1:0] size_code;
    logic [BASE_W-1:0] base;
  } job_t;

  // One tile element as it leaves the walker.
  typedef struct packed {
    logic              valid;
    logic [TILE_W-1:0] i;
    logic [TILE_W-1:0] j;
    logic              last;
    logic [RC_W-1:0]   r;
    logic [RC_W-1:0]   q;
    logic [DIM_W-1:0]  oh;
    logic [DIM_W-1:0]  ow;
    logic [ADDR_W-1:0] roff;
    logic [DIM_W-1:0]  c;
    logic [K_W-1:0]    kw;
    logic [K_W-1:0]    kh;
    logic [TR_W-1:0]   total_rows;
    logic [TC_W-1:0]   total_cols;
    logic              stride2;
    logic [PAD_W-1:0]  pad;
    logic [DIM_W-1:0]  img_h;
    logic [DIM_W-1:0]  img_w;
    logic [DIM_W-1:0]  chan;
    logic [CODE_W-1:0] size_code;
    logic [BASE_W-1:0] base;
  } elem_t;

endpackage

### rtl/itag_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on itag_pkg for its widths.
module itag_div import itag_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DSR_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W:0]   trial;
  logic             fits;

  // Trial subtraction of the shifted partial remainder.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  // Control: run until every dividend bit has been shifted through, then flag done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Data path of the shift and subtract.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/itag_setup.sv
// Setup unit: turns one tile request into the starting coordinates of the tile.
// Depends on itag_pkg and two itag_div instances.
module itag_setup import itag_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req,
  input  logic [IDX_W-1:0]  row_idx,
  input  logic [IDX_W-1:0]  col_idx,
  input  logic [CODE_W-1:0] size_code,
  input  logic [MODE_W-1:0] cfg_mode,
  input  logic [BASE_W-1:0] cfg_base,
  input  logic [N_W-1:0]    cfg_batch,
  input  logic [DIM_W-1:0]  cfg_height,
  input  logic [DIM_W-1:0]  cfg_width,
  input  logic [DIM_W-1:0]  cfg_chan,
  output logic              busy,
  output logic              job_valid,
  input  logic              job_take,
  output job_t              job
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_PREP1  = 10'b0000000010,
    ST_PREP2  = 10'b0000000100,
    ST_DIVAGO = 10'b0000001000,
    ST_DIVA   = 10'b0000010000,
    ST_DIVBGO = 10'b0000100000,
    ST_DIVB   = 10'b0001000000,
    ST_MUL1   = 10'b0010000000,
    ST_MUL2   = 10'b0100000000,
    ST_HOLD   = 10'b1000000000
  } st_t;

  localparam int HI_W = N_W + STR_W - MUL_SPLIT;

  st_t st_r, st_nxt;

  logic [IDX_W-1:0]      row_r;
  logic [IDX_W-1:0]      col_r;
  logic [2*DIM_W-1:0]    hw_r;
  logic [DSR_W-1:0]      rpi_r;
  logic [N_W-1:0]        n0_r;
  logic [DIV_W-1:0]      pr_r;
  logic [DIV_W-1:0]      tap_r;
  logic [N_W+MUL_SPLIT-1:0] plo_r;
  job_t                  job_r;

  logic                  div_go;
  logic                  div_first;
  logic [DIV_W-1:0]      a_dvd, b_dvd;
  logic [DSR_W-1:0]      a_dsr, b_dsr;
  logic                  a_done, b_done;
  logic [DIV_W-1:0]      a_quo, b_quo;
  logic [DSR_W-1:0]      a_rem, b_rem;
  logic [K_W-1:0]        kern;
  logic                  s2;
  logic [DIM_W-1:0]      oh_c, ow_c;
  logic [DIM_W:0]        h_inc, w_inc;

  // Output size of the current layout.
  assign kern  = lay_kernel(cfg_mode);
  assign s2    = lay_stride2(cfg_mode);
  assign h_inc = {1'b0, cfg_height} + 1'b1;
  assign w_inc = {1'b0, cfg_width} + 1'b1;
  assign oh_c  = (kern == '0) ? '0 : (s2 ? h_inc[DIM_W:1] : cfg_height);
  assign ow_c  = (kern == '0) ? '0 : (s2 ? w_inc[DIM_W:1] : cfg_width);

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (req) st_nxt = ST_PREP1;
      ST_PREP1:  st_nxt = ST_PREP2;
      ST_PREP2:  st_nxt = ST_DIVAGO;
      ST_DIVAGO: st_nxt = ST_DIVA;
      ST_DIVA:   if (a_done && b_done) st_nxt = ST_DIVBGO;
      ST_DIVBGO: st_nxt = ST_DIVB;
      ST_DIVB:   if (a_done && b_done) st_nxt = ST_MUL1;
      ST_MUL1:   st_nxt = ST_MUL2;
      ST_MUL2:   st_nxt = ST_HOLD;
      ST_HOLD:   if (job_take) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // Two dividers: row split on one, column split on the other.
  assign div_first = (st_r == ST_DIVAGO);
  assign div_go    = div_first || (st_r == ST_DIVBGO);
  assign a_dvd = div_first ? DIV_W'(job_r.r0) : pr_r;
  assign a_dsr = div_first ? rpi_r : DSR_W'(job_r.ow_cnt);
  assign b_dvd = div_first ? DIV_W'(job_r.q0) : tap_r;
  assign b_dsr = div_first ? DSR_W'(job_r.chan) : DSR_W'(job_r.kern);

  itag_div u_div_row (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(a_dvd), .divisor(a_dsr),
    .done(a_done), .quotient(a_quo), .remainder(a_rem)
  );

  itag_div u_div_col (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(b_dvd), .divisor(b_dsr),
    .done(b_done), .quotient(b_quo), .remainder(b_rem)
  );

  // Step registers of the setup sequence.
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (req) begin
          row_r           <= row_idx;
          col_r           <= col_idx;
          job_r.size_code <= size_code;
        end
      end
      ST_PREP1: begin
        job_r.r0      <= RC_W'(row_r) * RC_W'(TILE_DIM);
        job_r.q0      <= RC_W'(col_r) * RC_W'(TILE_DIM);
        job_r.kern    <= kern;
        job_r.stride2 <= s2;
        job_r.pad     <= lay_pad(cfg_mode);
        job_r.oh_cnt  <= oh_c;
        job_r.ow_cnt  <= ow_c;
        job_r.img_h   <= cfg_height;
        job_r.img_w   <= cfg_width;
        job_r.chan    <= cfg_chan;
        job_r.base    <= cfg_base;
        hw_r          <= (2*DIM_W)'(cfg_height) * (2*DIM_W)'(cfg_width);
      end
      ST_PREP2: begin
        rpi_r            <= DSR_W'(job_r.oh_cnt) * DSR_W'(job_r.ow_cnt);
        job_r.img_stride <= STR_W'(hw_r) * STR_W'(job_r.chan);
        job_r.total_cols <= TC_W'(job_r.kern) * TC_W'(job_r.kern) * TC_W'(job_r.chan);
      end
      ST_DIVAGO: begin
        job_r.total_rows <= TR_W'(cfg_batch) * TR_W'(rpi_r);
      end
      ST_DIVA: begin
        if (a_done && b_done) begin
          n0_r     <= a_quo[N_W-1:0];
          pr_r     <= a_rem[DIV_W-1:0];
          job_r.c0 <= b_rem[DIM_W-1:0];
          tap_r    <= b_quo;
        end
      end
      ST_DIVB: begin
        if (a_done && b_done) begin
          job_r.oh0 <= a_quo[DIM_W-1:0];
          job_r.ow0 <= a_rem[DIM_W-1:0];
          job_r.kh0 <= b_quo[K_W-1:0];
          job_r.kw0 <= b_rem[K_W-1:0];
        end
      end
      ST_MUL1: begin
        plo_r <= (N_W+MUL_SPLIT)'(n0_r)
               * (N_W+MUL_SPLIT)'(job_r.img_stride[MUL_SPLIT-1:0]);
      end
      ST_MUL2: begin
        job_r.roff0 <= ADDR_W'(plo_r)
                     + (ADDR_W'(HI_W'(n0_r) * HI_W'(job_r.img_stride[STR_W-1:MUL_SPLIT]))
                        << MUL_SPLIT);
      end
      default: begin
      end
    endcase
  end

  assign busy      = (st_r != ST_IDLE);
  assign job_valid = (st_r == ST_HOLD);
  assign job       = job_r;

endmodule

### rtl/itag_walk.sv
// Tile walker: steps through the tile elements in row-major order, one a cycle.
// Depends on itag_pkg; takes its start point from itag_setup.
module itag_walk import itag_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  job_valid,
  input  job_t  job,
  output logic  job_take,
  output elem_t el
);

  logic              active_r;
  job_t              job_r;
  logic [TILE_W-1:0] i_r, j_r;
  logic [RC_W-1:0]   r_r, q_r;
  logic [DIM_W-1:0]  oh_r, ow_r, c_r;
  logic [ADDR_W-1:0] roff_r;
  logic [K_W-1:0]    kw_r, kh_r;
  logic              row_end, at_last;

  assign row_end  = (j_r == TILE_LAST);
  assign at_last  = row_end && (i_r == TILE_LAST);
  assign job_take = job_valid && (!active_r || at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (job_take) begin
      active_r <= 1'b1;
    end else if (active_r && at_last) begin
      active_r <= 1'b0;
    end
  end

  // Counters of the output pixel and of the kernel tap and channel.
  always_ff @(posedge clk) begin
    if (job_take) begin
      job_r  <= job;
      i_r    <= '0;
      j_r    <= '0;
      r_r    <= job.r0;
      oh_r   <= job.oh0;
      ow_r   <= job.ow0;
      roff_r <= job.roff0;
      q_r    <= job.q0;
      c_r    <= job.c0;
      kw_r   <= job.kw0;
      kh_r   <= job.kh0;
    end else if (active_r) begin
      if (row_end) begin
        // Next matrix row: column side returns to its start.
        i_r  <= i_r + 1'b1;
        j_r  <= '0;
        q_r  <= job_r.q0;
        c_r  <= job_r.c0;
        kw_r <= job_r.kw0;
        kh_r <= job_r.kh0;
        r_r  <= r_r + 1'b1;
        if ({1'b0, ow_r} + 1'b1 == {1'b0, job_r.ow_cnt}) begin
          ow_r <= '0;
          if ({1'b0, oh_r} + 1'b1 == {1'b0, job_r.oh_cnt}) begin
            oh_r   <= '0;
            roff_r <= roff_r + ADDR_W'(job_r.img_stride);
          end else begin
            oh_r <= oh_r + 1'b1;
          end
        end else begin
          ow_r <= ow_r + 1'b1;
        end
      end else begin
        j_r <= j_r + 1'b1;
        q_r <= q_r + 1'b1;
        if ({1'b0, c_r} + 1'b1 == {1'b0, job_r.chan}) begin
          c_r <= '0;
          if ({1'b0, kw_r} + 1'b1 == {1'b0, job_r.kern}) begin
            kw_r <= '0;
            kh_r <= kh_r + 1'b1;
          end else begin
            kw_r <= kw_r + 1'b1;
          end
        end else begin
          c_r <= c_r + 1'b1;
        end
      end
    end
  end

  // The last flag is only raised on a live element.
  always_comb begin
    el.valid      = active_r;
    el.i          = i_r;
    el.j          = j_r;
    el.last       = active_r && at_last;
    el.r          = r_r;
    el.q          = q_r;
    el.oh         = oh_r;
    el.ow         = ow_r;
    el.roff       = roff_r;
    el.c          = c_r;
    el.kw         = kw_r;
    el.kh         = kh_r;
    el.total_rows = job_r.total_rows;
    el.total_cols = job_r.total_cols;
    el.stride2    = job_r.stride2;
    el.pad        = job_r.pad;
    el.img_h      = job_r.img_h;
    el.img_w      = job_r.img_w;
    el.chan       = job_r.chan;
    el.size_code  = job_r.size_code;
    el.base       = job_r.base;
  end

endmodule

### rtl/itag_addr.sv
// Six-stage address pipeline: bounds checks, linear index and byte address.
// Depends on itag_pkg; fed by itag_walk.
module itag_addr import itag_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  elem_t             el,
  output logic              out_valid,
  output logic [TILE_W-1:0] out_i,
  output logic [TILE_W-1:0] out_j,
  output logic              out_en,
  output logic [ADDR_W-1:0] out_addr,
  output logic              out_last
);

  localparam int CW = 16;

  typedef struct packed {
    logic [TILE_W-1:0] i;
    logic [TILE_W-1:0] j;
    logic              last;
  } tag_t;

  logic [5:0]            v_r;
  tag_t                  t1_r, t2_r, t3_r, t4_r, t5_r;
  logic                  ok1_r, ok2_r, ok3_r, ok4_r, ok5_r;
  logic signed [CW-1:0]  ih1_r, iw1_r;
  logic [ADDR_W-1:0]     roff1_r, roff2_r, roff3_r, roff4_r;
  logic [DIM_W-1:0]      c1_r, c2_r, c3_r, c4_r;
  logic [DIM_W-1:0]      h1_r, w1_r, ch1_r, ch2_r, ch3_r;
  logic [CODE_W-1:0]     sc1_r, sc2_r, sc3_r, sc4_r, sc5_r;
  logic [BASE_W-1:0]     b1_r, b2_r, b3_r, b4_r, b5_r;
  logic [2*DIM_W-1:0]    pix2_r, lin3_r;
  logic [DIM_W-1:0]      iw2_r;
  logic [ADDR_W-1:0]     lc4_r, idx5_r;
  logic [DIM_W:0]        ohs;
  logic [DIM_W:0]        ows;
  logic                  in_img;
  logic [ADDR_W-1:0]     scaled;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[4:0], el.valid};
  end

  // Stage 1: matrix bounds and input coordinates.
  assign ohs = el.stride2 ? {el.oh, 1'b0} : {1'b0, el.oh};
  assign ows = el.stride2 ? {el.ow, 1'b0} : {1'b0, el.ow};

  always_ff @(posedge clk) begin
    t1_r    <= '{i: el.i, j: el.j, last: el.last};
    ok1_r   <= (TR_W'(el.r) < el.total_rows) && (TC_W'(el.q) < el.total_cols);
    ih1_r   <= $signed(CW'(ohs)) + $signed(CW'(el.kh)) - $signed(CW'(el.pad));
    iw1_r   <= $signed(CW'(ows)) + $signed(CW'(el.kw)) - $signed(CW'(el.pad));
    roff1_r <= el.roff;
    c1_r    <= el.c;
    h1_r    <= el.img_h;
    w1_r    <= el.img_w;
    ch1_r   <= el.chan;
    sc1_r   <= el.size_code;
    b1_r    <= el.base;
  end

  // Stage 2: padding check and row offset inside the image.
  assign in_img = !ih1_r[CW-1] && !iw1_r[CW-1]
               && (ih1_r[CW-2:0] < (CW-1)'(h1_r)) && (iw1_r[CW-2:0] < (CW-1)'(w1_r));

  always_ff @(posedge clk) begin
    t2_r    <= t1_r;
    ok2_r   <= ok1_r && in_img;
    pix2_r  <= (2*DIM_W)'(ih1_r[DIM_W-1:0]) * (2*DIM_W)'(w1_r);
    iw2_r   <= iw1_r[DIM_W-1:0];
    roff2_r <= roff1_r;
    c2_r    <= c1_r;
    ch2_r   <= ch1_r;
    sc2_r   <= sc1_r;
    b2_r    <= b1_r;
  end

  // Stage 3: pixel index inside the image.
  always_ff @(posedge clk) begin
    t3_r    <= t2_r;
    ok3_r   <= ok2_r;
    lin3_r  <= pix2_r + (2*DIM_W)'(iw2_r);
    roff3_r <= roff2_r;
    c3_r    <= c2_r;
    ch3_r   <= ch2_r;
    sc3_r   <= sc2_r;
    b3_r    <= b2_r;
  end

  // Stage 4: scale by the channel count.
  always_ff @(posedge clk) begin
    t4_r    <= t3_r;
    ok4_r   <= ok3_r;
    lc4_r   <= ADDR_W'((3*DIM_W)'(lin3_r) * (3*DIM_W)'(ch3_r));
    roff4_r <= roff3_r;
    c4_r    <= c3_r;
    sc4_r   <= sc3_r;
    b4_r    <= b3_r;
  end

  // Stage 5: element index in the tensor.
  always_ff @(posedge clk) begin
    t5_r   <= t4_r;
    ok5_r  <= ok4_r;
    idx5_r <= roff4_r + lc4_r + ADDR_W'(c4_r);
    sc5_r  <= sc4_r;
    b5_r   <= b4_r;
  end

  // Stage 6: byte address; zero-fill elements carry address zero.
  always_comb begin
    case (sc5_r)
      SIZE_1B: scaled = idx5_r;
      SIZE_2B: scaled = idx5_r << 1;
      default: scaled = idx5_r << 2;
    endcase
  end

  always_ff @(posedge clk) begin
    out_i    <= t5_r.i;
    out_j    <= t5_r.j;
    out_last <= t5_r.last;
    out_en   <= ok5_r;
    out_addr <= ok5_r ? (ADDR_W'(b5_r) + scaled) : '0;
  end

  assign out_valid = v_r[5];

endmodule

### rtl/im2col_tile_address_generator_core.sv
// Top level of the im2col tile address generator: registers, setup, walker, pipeline.
// Depends on itag_pkg, itag_setup, itag_walk, itag_addr and the defines header.
//
// Use: write the layout and tensor registers through cfg_we/cfg_index/cfg_data
// while the block is idle. A request is taken at a clock edge with start high
// and busy low; it names one TILE_DIM x TILE_DIM subtile of the im2col matrix.
// The block then gives TILE_DIM*TILE_DIM results, one per cycle in row-major
// order, each marked by out_valid for exactly one cycle; out_last_of_tile
// flags the final one. Zero-fill elements have fetch_enable low, address zero.
// A request passes through the setup unit, the walker and the address pipeline
// in that order. The setup unit splits the tile origin with two serial
// dividers run in two passes, and busy stays high until the walker takes
// the finished job; the walker gives one element per cycle, and the next
// tile's setup can run while the current tile streams out. The address
// pipeline is six stages deep. The receiver cannot stall; results are never
// held.
// Synchronous reset empties setup, walker and pipeline and restores the
// registers to their reset values.
`include "im2col_tile_address_generator_core_defines.svh"
module im2col_tile_address_generator_core import itag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IDX_W-1:0]      in_tile_row_index,
  input  logic [IDX_W-1:0]      in_tile_col_index,
  input  logic [CODE_W-1:0]     in_element_size_code,
  output logic                  out_valid,
  output logic [2:0]            out_row_in_tile,
  output logic [2:0]            out_col_in_tile,
  output logic                  out_fetch_enable,
  output logic [ADDR_W-1:0]     out_fetch_address,
  output logic                  out_last_of_tile,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MODE_W-1:0] mode_r;
  logic [BASE_W-1:0] base_r;
  logic [N_W-1:0]    batch_r;
  logic [DIM_W-1:0]  height_r, width_r, chan_r;
  logic              job_valid, job_take;
  job_t              job;
  elem_t             el;
  logic [TILE_W-1:0] o_i, o_j;
  logic              out_corner;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= LAYOUT_K1S1P0;
      base_r   <= '0;
      batch_r  <= N_W'(1);
      height_r <= DIM_W'(1);
      width_r  <= DIM_W'(1);
      chan_r   <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LAYOUT:  mode_r   <= cfg_data[MODE_W-1:0];
        REG_BASE:    base_r   <= cfg_data[BASE_W-1:0];
        REG_BATCH:   batch_r  <= cfg_data[N_W-1:0];
        REG_HEIGHT:  height_r <= cfg_data[DIM_W-1:0];
        REG_WIDTH:   width_r  <= cfg_data[DIM_W-1:0];
        REG_CHANNEL: chan_r   <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request setup.
  itag_setup u_setup (
    .clk(clk), .rst_n(rst_n), .req(start && !busy),
    .row_idx(in_tile_row_index), .col_idx(in_tile_col_index),
    .size_code(in_element_size_code),
    .cfg_mode(mode_r), .cfg_base(base_r), .cfg_batch(batch_r),
    .cfg_height(height_r), .cfg_width(width_r), .cfg_chan(chan_r),
    .busy(busy), .job_valid(job_valid), .job_take(job_take), .job(job)
  );

  // Element walker.
  itag_walk u_walk (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
    .job_take(job_take), .el(el)
  );

  // Address pipeline.
  itag_addr u_addr (
    .clk(clk), .rst_n(rst_n), .el(el),
    .out_valid(out_valid), .out_i(o_i), .out_j(o_j),
    .out_en(out_fetch_enable), .out_addr(out_fetch_address),
    .out_last(out_last_of_tile)
  );

  assign out_row_in_tile = 3'(o_i);
  assign out_col_in_tile = 3'(o_j);

  // Corner element of a tile.
  assign out_corner = (out_row_in_tile == 3'(TILE_DIM - 1))
                   && (out_col_in_tile == 3'(TILE_DIM - 1));

  // A taken request keeps the setup unit occupied.
  `ITAG_ASSERT_NEXT(a_req_busy, start && !busy, busy)
  // Zero-fill results carry address zero.
  `ITAG_ASSERT_NOW(a_zero_addr, out_valid && !out_fetch_enable, out_fetch_address == '0)
  // Last flag only on the corner element of a tile.
  `ITAG_ASSERT_NOW(a_last_pos, out_last_of_tile, out_valid && out_corner)
  // Elements of one tile come without gaps.
  `ITAG_ASSERT_NOW(a_no_gap, out_valid && out_col_in_tile != 3'd0, $past(out_valid))

endmodule

### verif/im2col_tile_address_generator_core_test.sv
// Self-checking testbench for the im2col tile address generator core.
// Depends on itag_pkg and im2col_tile_address_generator_core only.
// Directed table first, then random layouts and tiles checked against a local predictor.
`timescale 1ns / 100ps
module im2col_tile_address_generator_core_test;
  import itag_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PHASES = 14;
  localparam int ITEMS_PER_PHASE = 25;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [IDX_W-1:0]      in_tile_row_index;
  logic [IDX_W-1:0]      in_tile_col_index;
  logic [CODE_W-1:0]     in_element_size_code;
  logic                  out_valid;
  logic [2:0]            out_row_in_tile;
  logic [2:0]            out_col_in_tile;
  logic                  out_fetch_enable;
  logic [ADDR_W-1:0]     out_fetch_address;
  logic                  out_last_of_tile;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  im2col_tile_address_generator_core dut (.*);

  // One expected tile element.
  typedef struct {
    logic [2:0]        row;
    logic [2:0]        col;
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } tile_elem_t;

  // One row of the directed table: layout, request and an optional typed
  // value for the first element of the tile.
  typedef struct {
    logic [2:0]  mode;
    logic [31:0] base;
    int          nb;
    int          hh;
    int          ww;
    int          cc;
    logic [15:0] trow;
    logic [15:0] tcol;
    logic [1:0]  code;
    bit          typed;
    bit          en0;
    logic [47:0] addr0;
  } tile_case_t;

  localparam int NUM_CASES = 22;
  tile_case_t tile_cases [NUM_CASES] = '{
    '{LAYOUT_K1S1P0, 32'h0, 1, 1, 1, 1, 16'h0, 16'h0, SIZE_1B, 1, 1, 48'h0},
    '{LAYOUT_K1S1P0, 32'hFFFF_FFFF, 1, 1, 1, 1, 16'h0, 16'h0, 2'd2, 1, 1, 48'hFFFF_FFFF},
    '{3'd5, 32'h100, 2, 5, 5, 3, 16'h0, 16'h0, SIZE_1B, 1, 0, 48'h0},
    '{3'd6, 32'h100, 2, 5, 5, 3, 16'h0, 16'h0, SIZE_2B, 1, 0, 48'h0},
    '{3'd7, 32'h100, 2, 5, 5, 3, 16'h1, 16'h0, 2'd3, 1, 0, 48'h0},
    '{LAYOUT_K3S1P1, 32'h100, 0, 5, 5, 3, 16'h0, 16'h0, SIZE_1B, 1, 0, 48'h0},
    '{LAYOUT_K3S1P1, 32'h100, 2, 0, 5, 3, 16'h0, 16'h0, SIZE_1B, 1, 0, 48'h0},
    '{LAYOUT_K3S1P1, 32'h100, 2, 5, 0, 3, 16'h0, 16'h0, SIZE_1B, 1, 0, 48'h0},
    '{LAYOUT_K3S1P1, 32'h100, 2, 5, 5, 0, 16'h0, 16'h0, SIZE_1B, 1, 0, 48'h0},
    '{LAYOUT_K1S1P0, 32'h40, 1, 3, 3, 4, 16'h0, 16'h0, 2'd3, 0, 0, 48'h0},
    '{LAYOUT_K1S1P0, 32'h40, 2, 3, 3, 4, 16'h1, 16'h0, SIZE_2B, 0, 0, 48'h0},
    '{LAYOUT_K3S1P1, 32'h1000, 1, 5, 5, 3, 16'h0, 16'h0, SIZE_1B, 0, 0, 48'h0},
    '{LAYOUT_K3S1P1, 32'h1000, 2, 5, 5, 3, 16'h2, 16'h1, SIZE_2B, 0, 0, 48'h0},
    '{LAYOUT_K3S2P1, 32'h1000, 1, 7, 6, 2, 16'h0, 16'h1, 2'd2, 0, 0, 48'h0},
    '{LAYOUT_K3S2P1, 32'h1000, 2, 7, 6, 2, 16'h3, 16'h2, SIZE_1B, 0, 0, 48'h0},
    '{LAYOUT_K5S1P2, 32'h2000, 1, 6, 5, 2, 16'h1, 16'h3, SIZE_2B, 0, 0, 48'h0},
    '{LAYOUT_K7S2P3, 32'h3000, 1, 9, 9, 1, 16'h0, 16'h2, SIZE_1B, 0, 0, 48'h0},
    '{LAYOUT_K7S2P3, 32'h3000, 2, 9, 9, 1, 16'h5, 16'h4, 2'd2, 0, 0, 48'h0},
    '{LAYOUT_K1S1P0, 32'h0, 256, 4096, 4096, 4096, 16'h0, 16'h0, SIZE_1B, 1, 1, 48'h0},
    '{LAYOUT_K1S1P0, 32'h0, 256, 4096, 4096, 4096, 16'hFFFF, 16'h0, SIZE_2B,
      1, 1, 48'hFFFF_0000},
    '{LAYOUT_K7S2P3, 32'hFFFF_FFFF, 256, 4096, 4096, 4096, 16'hFFFF, 16'hFFFF, 2'd3,
      0, 0, 48'h0},
    '{LAYOUT_K5S1P2, 32'hFFFF_FFF0, 256, 4096, 4096, 4096, 16'h8000, 16'h7FFF, 2'd2,
      0, 0, 48'h0}
  };

  // Local copy of the configuration registers.
  logic [2:0]  layout_sh;
  logic [31:0] base_sh;
  logic [8:0]  batch_sh;
  logic [12:0] height_sh;
  logic [12:0] width_sh;
  logic [12:0] chan_sh;

  tile_elem_t expected_elems[$];
  int  error_count;
  int  cycle_count;
  bit  idling_on;

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Overall watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic bit lay_stride2_tb();
    return (layout_sh == LAYOUT_K3S2P1) || (layout_sh == LAYOUT_K7S2P3);
  endfunction

  // Matrix extent under the current layout.
  function automatic void matrix_extent(output longint unsigned rows,
                                        output longint unsigned cols);
    longint unsigned k;
    longint unsigned oh_n;
    longint unsigned ow_n;
    k = (layout_sh == LAYOUT_K1S1P0) ? 1 :
        (layout_sh == LAYOUT_K3S1P1 || layout_sh == LAYOUT_K3S2P1) ? 3 :
        (layout_sh == LAYOUT_K5S1P2) ? 5 : (layout_sh == LAYOUT_K7S2P3) ? 7 : 0;
    oh_n = (k == 0) ? 0 : lay_stride2_tb() ? (height_sh + 1) / 2 : height_sh;
    ow_n = (k == 0) ? 0 : lay_stride2_tb() ? (width_sh + 1) / 2 : width_sh;
    rows = batch_sh * oh_n * ow_n;
    cols = k * k * chan_sh;
  endfunction

  // Expected addresses of one tile, queued in row-major order.
  function automatic void predict_tile(logic [15:0] trow, logic [15:0] tcol,
                                       logic [1:0] code);
    longint unsigned k, s, p, rows_img, tot_r, tot_c, r, q, n, pr, oh, ow, c, tap;
    longint unsigned bytes, idx, img_stride, oh_n, ow_n;
    longint ih, iw;
    tile_elem_t e;
    k = (layout_sh == LAYOUT_K1S1P0) ? 1 :
        (layout_sh == LAYOUT_K3S1P1 || layout_sh == LAYOUT_K3S2P1) ? 3 :
        (layout_sh == LAYOUT_K5S1P2) ? 5 : (layout_sh == LAYOUT_K7S2P3) ? 7 : 0;
    s = lay_stride2_tb() ? 2 : 1;
    p = (layout_sh == LAYOUT_K3S1P1 || layout_sh == LAYOUT_K3S2P1) ? 1 :
        (layout_sh == LAYOUT_K5S1P2) ? 2 : (layout_sh == LAYOUT_K7S2P3) ? 3 : 0;
    bytes = (code == SIZE_1B) ? 1 : (code == SIZE_2B) ? 2 : 4;
    oh_n = (k == 0) ? 0 : (s == 2) ? (height_sh + 1) / 2 : height_sh;
    ow_n = (k == 0) ? 0 : (s == 2) ? (width_sh + 1) / 2 : width_sh;
    rows_img = oh_n * ow_n;
    matrix_extent(tot_r, tot_c);
    img_stride = longint'(height_sh) * width_sh * chan_sh;
    for (int i = 0; i < TILE_DIM; i++) begin
      for (int j = 0; j < TILE_DIM; j++) begin
        r = longint'(trow) * TILE_DIM + i;
        q = longint'(tcol) * TILE_DIM + j;
        e.row = i[2:0];
        e.col = j[2:0];
        e.en = 1'b0;
        e.addr = '0;
        e.last = (i == TILE_DIM - 1) && (j == TILE_DIM - 1);
        if (r < tot_r && q < tot_c) begin
          n = r / rows_img;
          pr = r % rows_img;
          oh = pr / ow_n;
          ow = pr % ow_n;
          c = q % chan_sh;
          tap = q / chan_sh;
          ih = longint'(oh * s) - longint'(p) + longint'(tap / k);
          iw = longint'(ow * s) - longint'(p) + longint'(tap % k);
          if (ih >= 0 && iw >= 0 && ih < longint'(height_sh) && iw < longint'(width_sh))
          begin
            idx = n * img_stride + (longint'(ih) * width_sh + longint'(iw)) * chan_sh + c;
            e.en = 1'b1;
            e.addr = 48'(base_sh + idx * bytes);
          end
        end
        expected_elems.push_back(e);
      end
    end
  endfunction

  // Register write, one cycle of cfg_we.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_LAYOUT:  layout_sh = value[2:0];
      REG_BASE:    base_sh = value;
      REG_BATCH:   batch_sh = value[8:0];
      REG_HEIGHT:  height_sh = value[12:0];
      REG_WIDTH:   width_sh = value[12:0];
      REG_CHANNEL: chan_sh = value[12:0];
      default: ;
    endcase
  endtask

  // Writes only the registers whose value changes.
  task automatic apply_layout(logic [2:0] mode, logic [31:0] base, int nb, int hh,
                              int ww, int cc);
    if (mode != layout_sh) write_reg(REG_LAYOUT, mode);
    if (base != base_sh) write_reg(REG_BASE, base);
    if (nb[8:0] != batch_sh) write_reg(REG_BATCH, nb);
    if (hh[12:0] != height_sh) write_reg(REG_HEIGHT, hh);
    if (ww[12:0] != width_sh) write_reg(REG_WIDTH, ww);
    if (cc[12:0] != chan_sh) write_reg(REG_CHANNEL, cc);
  endtask

  // Holds off until every expected element has arrived and the block is quiet.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Issues one request and queues its expected elements once it is taken.
  task automatic send_request(logic [15:0] trow, logic [15:0] tcol, logic [1:0] code,
                              bit typed, bit en0, logic [47:0] addr0);
    tile_elem_t first;
    if (idling_on && $urandom_range(99) < 16) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_tile_row_index = trow;
    in_tile_col_index = tcol;
    in_element_size_code = code;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_tile(trow, tcol, code);
    // Typed first element replaces the predicted one.
    if (typed) begin
      first = expected_elems[expected_elems.size() - TILE_DIM * TILE_DIM];
      first.en = en0;
      first.addr = addr0;
      expected_elems[expected_elems.size() - TILE_DIM * TILE_DIM] = first;
    end
  endtask

  function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, got_v);
      error_count++;
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    tile_elem_t e;
    if (rst_n && out_valid) begin
      if (expected_elems.size() == 0) begin
        $display("%0t: unexpected result, expected none, got row %0d col %0d", $realtime,
                 out_row_in_tile, out_col_in_tile);
        error_count++;
      end else begin
        e = expected_elems.pop_front();
        check_field("row_in_tile", e.row, out_row_in_tile);
        check_field("col_in_tile", e.col, out_col_in_tile);
        check_field("fetch_enable", e.en, out_fetch_enable);
        check_field("fetch_address", e.addr, out_fetch_address);
        check_field("last_of_tile", e.last, out_last_of_tile);
      end
    end
  end

  // Stimulus.
  initial begin
    longint unsigned rows, cols, row_tiles, col_tiles;
    logic [2:0] mode;
    int nb, hh, ww, cc;
    logic [15:0] trow, tcol;
    error_count = 0;
    cycle_count = 0;
    idling_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_tile_row_index = '0;
    in_tile_col_index = '0;
    in_element_size_code = '0;
    cfg_we = 1'b0;
    cfg_index = REG_LAYOUT;
    cfg_data = '0;
    layout_sh = LAYOUT_K1S1P0;
    base_sh = '0;
    batch_sh = 9'd1;
    height_sh = 13'd1;
    width_sh = 13'd1;
    chan_sh = 13'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    for (int t = 0; t < NUM_CASES; t++) begin
      wait_idle();
      apply_layout(tile_cases[t].mode, tile_cases[t].base, tile_cases[t].nb,
                   tile_cases[t].hh, tile_cases[t].ww, tile_cases[t].cc);
      send_request(tile_cases[t].trow, tile_cases[t].tcol, tile_cases[t].code,
                   tile_cases[t].typed, tile_cases[t].en0, tile_cases[t].addr0);
    end

    // Random phases; each starts from an idle block with a fresh layout.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      idling_on = (ph != 3);
      mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      if ($urandom_range(5) == 0) begin
        nb = $urandom_range(256, 200);
        hh = $urandom_range(4096, 3000);
        ww = $urandom_range(4096, 3000);
        cc = $urandom_range(4096, 1000);
      end else begin
        nb = $urandom_range(4, 1);
        hh = $urandom_range(12, 1);
        ww = $urandom_range(12, 1);
        cc = $urandom_range(20, 1);
      end
      apply_layout(mode, $urandom(), nb, hh, ww, cc);
      matrix_extent(rows, cols);
      row_tiles = rows / TILE_DIM + 1;
      col_tiles = cols / TILE_DIM + 1;
      if (row_tiles > 65535) row_tiles = 65535;
      if (col_tiles > 65535) col_tiles = 65535;
      for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
        trow = ($urandom_range(4) == 0) ? 16'($urandom()) : 16'($urandom_range(row_tiles));
        tcol = ($urandom_range(4) == 0) ? 16'($urandom()) : 16'($urandom_range(col_tiles));
        send_request(trow, tcol, 2'($urandom_range(3)), 1'b0, 1'b0, '0);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
